// ----- rtl/core/ald_pkg.sv -----
// shared types and constants for the ascii length-prefix deframer
`default_nettype none

package ald_pkg;

  // width of lengths, counts and the max_length register
  localparam int unsigned LenW = 14;

  // defaults for the top-level parameters
  localparam int unsigned HeaderDigitsDefault = 4;
  localparam int unsigned MaxPacketDefault    = 9999;

  // max_length after reset
  localparam logic [LenW-1:0] MaxLengthReset = LenW'(100);

  // digit accumulator saturation value
  localparam logic [LenW-1:0] ValueCap = {LenW{1'b1}};

  // ascii codes used by the header parser
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // header parse phase
  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } ald_phase_e;

  // one result transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       length_error;
  } ald_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ald_core.sv -----
// framing state and per-byte header parse and length check
`default_nettype none

module ald_core import ald_pkg::*; #(
  parameter int unsigned HEADER_DIGITS = HeaderDigitsDefault,
  parameter int unsigned MAX_PACKET    = MaxPacketDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic [LenW-1:0] max_length_i,
  output ald_result_t          result_o
);

  localparam logic [LenW-1:0] HdLen  = LenW'(HEADER_DIGITS);
  localparam logic [LenW-1:0] MaxPkt = LenW'(MAX_PACKET);

  logic [LenW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] pkt_len_q, pkt_len_d;
  logic [LenW-1:0] hv_q, hv_d;
  ald_phase_e      ph_q, ph_d;
  logic            neg_q, neg_d;

  logic            is_digit, is_blank, is_sign, acc_en;
  logic [3:0]      digit_val;
  logic [LenW+3:0] acc_sum;
  logic [LenW-1:0] acc_val, cnt_inc;
  logic            bad_len, first, last, err;

  // character classes
  assign is_digit  = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_blank  = (byte_i == ChSpace) || ((byte_i >= ChTab) && (byte_i <= ChCr));
  assign is_sign   = (byte_i == ChPlus) || (byte_i == ChMinus);
  assign digit_val = 4'(byte_i - ChZero);

  // decimal accumulate with saturation, value * 10 as shift and add
  assign acc_sum = {hv_q, 3'b000} + {2'b00, hv_q, 1'b0} + {{LenW{1'b0}}, digit_val};
  assign acc_val = (acc_sum > {4'b0000, ValueCap}) ? ValueCap : acc_sum[LenW-1:0];

  assign cnt_inc = cnt_q + LenW'(1);

  // atoi-style parse of one header character
  always_comb begin
    ph_d   = ph_q;
    neg_d  = neg_q;
    acc_en = 1'b0;
    case (ph_q)
      PH_BLANK: begin
        if (is_blank) begin
          ph_d = PH_BLANK;
        end else if (is_sign) begin
          neg_d = (byte_i == ChMinus);
          ph_d  = PH_DIGITS;
        end else if (is_digit) begin
          ph_d   = PH_DIGITS;
          acc_en = 1'b1;
        end else begin
          ph_d = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc_en = 1'b1;
        end else begin
          ph_d = PH_DONE;
        end
      end
      PH_DONE: ph_d = PH_DONE;
      default: ph_d = PH_DONE;
    endcase
  end

  assign hv_d = acc_en ? acc_val : hv_q;

  // length check on the last header byte; zero length is below the header size
  assign bad_len = neg_q && !(hv_d == '0) ? 1'b1 :
                   (hv_d < HdLen) || (hv_d > max_length_i) || (hv_d > MaxPkt);

  // framing decisions and next state
  always_comb begin
    first     = (cnt_q == '0);
    last      = 1'b0;
    err       = 1'b0;
    cnt_d     = cnt_inc;
    pkt_len_d = pkt_len_q;
    if (pkt_len_q == '0) begin
      if (cnt_inc >= HdLen) begin
        if (bad_len || neg_d) begin
          err = 1'b1;
        end else if (hv_d == cnt_inc) begin
          last = 1'b1;
        end else begin
          pkt_len_d = hv_d;
        end
      end
    end else if (cnt_inc >= pkt_len_q) begin
      last = 1'b1;
    end
  end

  assign result_o = '{data_byte: byte_i, first_byte: first, last_byte: last,
                      length_error: err};

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pkt_len_q <= '0;
      hv_q      <= '0;
      ph_q      <= PH_BLANK;
      neg_q     <= 1'b0;
    end else if (step_i) begin
      if (last || err) begin
        cnt_q     <= '0;
        pkt_len_q <= '0;
        hv_q      <= '0;
        ph_q      <= PH_BLANK;
        neg_q     <= 1'b0;
      end else if (pkt_len_q == '0) begin
        cnt_q     <= cnt_d;
        pkt_len_q <= pkt_len_d;
        hv_q      <= hv_d;
        ph_q      <= ph_d;
        neg_q     <= neg_d;
      end else begin
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ascii_length_prefix_deframer.sv -----
// top level of the ascii length-prefix deframer: input stage, result stage, config
`default_nettype none

// Splits a byte stream into packets whose first HEADER_DIGITS bytes hold the
// total length as ascii decimal (blanks, optional sign, digits). One byte is
// taken per cycle unless the output is back-pressured; a result is presented
// from the result register once its input has passed the input register, and
// the input stage stalls behind a held result. Zero bytes are consumed
// and produce no result. A length that is not positive, shorter than the
// header, above max_length or above MAX_PACKET is flagged on the last header
// byte with length_error, and the next byte starts a new header. max_length
// resets to 100 and should only be written while the block is idle.
module ascii_length_prefix_deframer import ald_pkg::*; #(
  parameter int unsigned HEADER_DIGITS = HeaderDigitsDefault,
  parameter int unsigned MAX_PACKET    = MaxPacketDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [LenW-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      rx_byte_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           data_byte_o,
  output logic                 first_byte_o,
  output logic                 last_byte_o,
  output logic                 length_error_o
);

  logic [LenW-1:0] max_length_q;
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            out_valid_q;
  ald_result_t     out_q, result;
  logic            out_free, step, in_done;

  // max_length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthReset;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  // stage handshakes
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && (in_byte_q != 8'h00) && out_free;
  assign in_done    = in_valid_q && ((in_byte_q == 8'h00) || out_free);
  assign in_ready_o = !in_valid_q || in_done;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (in_done) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  ald_core #(
    .HEADER_DIGITS (HEADER_DIGITS),
    .MAX_PACKET    (MAX_PACKET)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_byte_q),
    .max_length_i (max_length_q),
    .result_o     (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_q.data_byte;
  assign first_byte_o   = out_q.first_byte;
  assign last_byte_o    = out_q.last_byte;
  assign length_error_o = out_q.length_error;

endmodule

`default_nettype wire

// ----- test/ald_checker.sv -----
// checker for the ascii length-prefix deframer: predicts each result and compares it
module ald_checker import ald_pkg::*; #(
  parameter int unsigned HEADER_DIGITS = HeaderDigitsDefault,
  parameter int unsigned MAX_PACKET    = MaxPacketDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [7:0]      data_byte_i,
  input  logic            first_byte_i,
  input  logic            last_byte_i,
  input  logic            length_error_i,
  output int              error_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the deframer state
  logic [LenW-1:0] max_len;
  logic [LenW-1:0] byte_cnt;
  logic [LenW-1:0] pkt_len;
  logic [LenW-1:0] hdr_value;
  ald_phase_e      phase;
  logic            neg_seen;

  // results still owed by the block, oldest first
  ald_result_t expected_q[$];

  function automatic void clear_packet();
    byte_cnt  = '0;
    pkt_len   = '0;
    hdr_value = '0;
    phase     = PH_BLANK;
    neg_seen  = 1'b0;
  endfunction

  // one stream byte in, zero or one packet byte out
  function automatic bit predict_byte(input logic [7:0] c, output ald_result_t res);
    logic            is_digit;
    logic            is_blank;
    logic            bad;
    logic [LenW-1:0] len;
    int unsigned     acc;
    res = '0;
    if (c == 8'h00) return 1'b0;
    is_digit = (c >= ChZero) && (c <= ChNine);
    is_blank = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    res.data_byte  = c;
    res.first_byte = (byte_cnt == 0);
    if (pkt_len == 0) begin
      // atoi style parse: blanks, optional sign, digits
      if (phase == PH_BLANK) begin
        if (c == ChPlus || c == ChMinus) begin
          neg_seen = (c == ChMinus);
          phase    = PH_DIGITS;
          is_digit = 1'b0;
        end else if (!is_blank) begin
          phase = is_digit ? PH_DIGITS : PH_DONE;
        end
      end else if (phase == PH_DIGITS && !is_digit) begin
        phase = PH_DONE;
      end
      if (phase == PH_DIGITS && is_digit) begin
        acc = 32'(hdr_value) * 32'd10 + 32'(c) - 32'(ChZero);
        hdr_value = (acc > 32'(ValueCap)) ? ValueCap : acc[LenW-1:0];
      end
      byte_cnt++;
      // length is known once the whole header is in
      if (byte_cnt >= HEADER_DIGITS) begin
        len = hdr_value;
        bad = (neg_seen && len != 0) || len == 0 || len < HEADER_DIGITS ||
              len > max_len || len > MAX_PACKET;
        if (bad) begin
          res.length_error = 1'b1;
          clear_packet();
        end else if (len == byte_cnt) begin
          res.last_byte = 1'b1;
          clear_packet();
        end else begin
          pkt_len = len;
        end
      end
    end else begin
      byte_cnt++;
      if (byte_cnt >= pkt_len) begin
        res.last_byte = 1'b1;
        clear_packet();
      end
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count_o++;
    end
  endfunction

  // watch both channels and the config port
  always @(posedge clk_i or negedge rst_ni) begin : watch
    ald_result_t want;
    ald_result_t pred;
    if (!rst_ni) begin
      max_len = MaxLengthReset;
      clear_packet();
      expected_q.delete();
      error_count_o = 0;
    end else begin
      if (cfg_we_i) max_len = cfg_wdata_i;
      // result transaction against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no expectation waiting: data_byte %0h", data_byte_i);
          error_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("data_byte", want.data_byte, data_byte_i);
          check_field("first_byte", 8'(want.first_byte), 8'(first_byte_i));
          check_field("last_byte", 8'(want.last_byte), 8'(last_byte_i));
          check_field("length_error", 8'(want.length_error), 8'(length_error_i));
        end
      end
      // input transaction
      if (in_valid_i && in_ready_i && predict_byte(rx_byte_i, pred)) begin
        expected_q.push_back(pred);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ----- test/tb.sv -----
// testbench top for the ascii length-prefix deframer: stimulus, idling and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ald_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 230;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned HdrLen     = HeaderDigitsDefault;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [LenW-1:0] cfg_wdata = '0;
  logic            in_valid  = 1'b0;
  logic [7:0]      rx_byte   = 8'h00;
  logic            out_ready = 1'b0;
  logic            in_ready;
  logic            out_valid;
  logic [7:0]      data_byte;
  logic            first_byte;
  logic            last_byte;
  logic            length_error;
  int              error_count;
  int              pending;

  int unsigned     sender_idle_pct = 0;
  int unsigned     recv_stall_pct  = 0;
  bit              hold_req        = 1'b0;
  int unsigned     items_sent      = 0;
  int unsigned     cycle_count     = 0;
  logic [LenW-1:0] max_len_now     = MaxLengthReset;

  ascii_length_prefix_deframer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .data_byte_o    (data_byte),
    .first_byte_o   (first_byte),
    .last_byte_o    (last_byte),
    .length_error_o (length_error)
  );

  ald_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .data_byte_i    (data_byte),
    .first_byte_i   (first_byte),
    .last_byte_i    (last_byte),
    .length_error_i (length_error),
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (b != 8'h00) items_sent++;
  endtask

  // stream byte, now and then preceded by an ignored zero byte
  task automatic send_stream_byte(input logic [7:0] b);
    if ($urandom_range(0, 24) == 0) send_byte(8'h00);
    send_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // nonzero byte that is no digit; plain also rules out blanks and signs
  function automatic logic [7:0] text_byte(input bit plain);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while ((b >= ChZero && b <= ChNine) ||
               (plain && (b == ChSpace || (b >= ChTab && b <= ChCr) ||
                          b == ChPlus || b == ChMinus)));
    return b;
  endfunction

  // header text: blanks, sign, zero padding, digits, trailing text
  task automatic send_header(input int unsigned len, input bit minus);
    logic [7:0]  hdr [HdrLen];
    int unsigned ndig, div, room, n_sign, n_zero, n_blank, pos;
    ndig = 1;
    div  = 1;
    while (div * 10 <= len) begin
      div *= 10;
      ndig++;
    end
    room    = HdrLen - ndig;
    n_sign  = minus ? 1 : ((room > 0 && $urandom_range(0, 3) == 0) ? 1 : 0);
    room   -= n_sign;
    n_zero  = $urandom_range(0, room);
    room   -= n_zero;
    n_blank = $urandom_range(0, room);
    pos     = 0;
    repeat (n_blank) begin
      hdr[pos] = ($urandom_range(0, 5) == 0) ? ChSpace : ChTab + 8'($urandom_range(0, 4));
      pos++;
    end
    if (n_sign != 0) begin
      hdr[pos] = minus ? ChMinus : ChPlus;
      pos++;
    end
    repeat (n_zero) begin
      hdr[pos] = ChZero;
      pos++;
    end
    while (div > 0) begin
      hdr[pos] = ChZero + 8'((len / div) % 10);
      pos++;
      div /= 10;
    end
    while (pos < HdrLen) begin
      hdr[pos] = text_byte(1'b0);
      pos++;
    end
    foreach (hdr[i]) send_stream_byte(hdr[i]);
  endtask

  // one packet: mostly well formed, the rest noise or bad lengths
  task automatic send_packet();
    int unsigned r, len, hi;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // text header, reads as length zero
      send_stream_byte(text_byte(1'b1));
      repeat (HdrLen - 1) send_stream_byte(8'($urandom_range(1, 255)));
    end else if (r < 18) begin
      send_header($urandom_range(0, 999), 1'b1);
    end else if (r < 26 || max_len_now < HdrLen) begin
      // too short, or above max_length
      if (max_len_now >= MaxPacketDefault || $urandom_range(0, 1) == 0) begin
        len = $urandom_range(0, HdrLen - 1);
      end else begin
        hi  = (max_len_now + 60 > MaxPacketDefault) ? MaxPacketDefault : max_len_now + 60;
        len = $urandom_range(max_len_now + 1, hi);
      end
      send_header(len, 1'b0);
    end else begin
      hi = ($urandom_range(0, 24) == 0) ? 250 : 40;
      if (hi > max_len_now) hi = max_len_now;
      len = $urandom_range(HdrLen, hi);
      send_header(len, 1'b0);
      repeat (len - HdrLen) send_stream_byte(8'($urandom_range(1, 255)));
    end
  endtask

  // stop offering and wait until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_max(input logic [LenW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    max_len_now = v;
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [LenW-1:0] settings [8];
    int unsigned     phase_start;
    settings    = '{LenW'(9999), LenW'(37), LenW'(0), LenW'(4),
                    LenW'(9998), LenW'(0), LenW'(1000), LenW'(16)};
    settings[5] = LenW'($urandom_range(0, 9999));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cases at the reset max_length
    send_text("0004");
    send_text("\t-12");
    send_text("+006");
    send_byte(8'hFF);
    send_byte(8'h01);
    send_text("0003");
    send_text("05");
    send_byte(8'h00);
    send_text(":");
    send_byte(8'h7F);
    send_text("0101");
    wait_idle();

    // random phases, one max_length setting and idle mode each
    for (int p = 0; p < 8; p++) begin
      write_max(settings[p]);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
          hold_req        = 1'b1;
        end
        1: begin
          sender_idle_pct = 49;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 49;
        end
        default: begin
          sender_idle_pct = 27;
          recv_stall_pct  = 27;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) send_packet();
      wait_idle();
    end

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
